### rtl/cblm_pkg.sv
package cblm_pkg;

	// Ring geometry. Address and count widths follow from the depth.
	localparam int SAMPLE_DEPTH = 1024;
	localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
	localparam int COUNT_W      = $clog2(SAMPLE_DEPTH + 1);

	localparam int TS_W    = 64;
	localparam int WIN_W   = 40;
	localparam int TOT_W   = 48;
	localparam int WF_W    = 11;
	localparam int WB_W    = 18;
	localparam int BITS_W  = 8;
	localparam int LEN_W   = 4;
	localparam int ENTRY_W = TS_W + BITS_W;

	localparam logic [WIN_W-1:0] WINDOW_RESET = 40'd1000000000;
	localparam logic [TOT_W-1:0] TOTAL_MAX    = '1;

	// Item commands.
	localparam logic CMD_FRAME = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic             cmd;
		logic [TS_W-1:0]  item_time;
		logic [LEN_W-1:0] payload_length;
		logic             extended_id;
	} item_t;

	typedef struct packed {
		logic [TOT_W-1:0] total_frames;
		logic [TOT_W-1:0] total_payload_bytes;
		logic [WF_W-1:0]  window_frames;
		logic [WB_W-1:0]  window_bits;
		logic             ring_overflow;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_EVICT = 4'b0010,
		ST_PUSH  = 4'b0100,
		ST_CHECK = 4'b1000
	} state_t;

endpackage

### rtl/cblm_ram.sv
module cblm_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read-before-write: a read of the address being written returns old data.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### rtl/cblm_est.sv
module cblm_est (
	input  logic [cblm_pkg::LEN_W-1:0]  payload_length,
	input  logic                        extended_id,
	output logic [cblm_pkg::BITS_W-1:0] frame_bits
);

	logic [3:0]  len_clamped;
	logic [7:0]  raw;
	logic [7:0]  raw_round;
	logic [15:0] prod;

	// Stuffing allowance is ceil(raw/5); raw+4 stays below 1024, so the
	// reciprocal multiply by 205/1024 gives the exact quotient.
	always_comb begin
		len_clamped = (payload_length > 4'd8) ? 4'd8 : payload_length;
		raw         = (extended_id ? 8'd67 : 8'd47) + {1'b0, len_clamped, 3'b000};
		raw_round   = raw + 8'd4;
		prod        = 16'(raw_round) * 16'd205;
		frame_bits  = raw + {2'b00, prod[15:10]};
	end

endmodule

### rtl/can_bus_load_window_monitor_unit.sv
// CAN bus load window monitor. Each item beat is a received frame or a query
// with a time in nanoseconds; each produces exactly one result beat holding the
// saturating frame and byte totals, the count and estimated bit sum of frames
// still inside the sliding window, and a sticky ring overflow flag. Samples are
// kept in a ring of SAMPLE_DEPTH entries in a single-port-write, registered-read
// memory, and the window is trimmed by reading the ring head once per cycle.
// A query runs the check state, a frame push then check, and a frame meeting a
// full ring evict first; each expiring sample adds a check, as every test of
// the oldest sample waits for the registered read of the ring head. A new item
// beat is taken as soon as the previous one has reached the result register,
// even while that result is still stalled. The window length register must be
// written only while the block is idle; the block does not enforce this. The
// memory needs no clearing after reset: only entries in the ring are ever used.
module can_bus_load_window_monitor_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  cblm_pkg::item_t                   item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output cblm_pkg::result_t                 result,
	input  logic                              cfg_we,
	input  logic [cblm_pkg::WIN_W-1:0]        cfg_wdata
);

	localparam int AW = cblm_pkg::ADDR_W;
	localparam int CW = cblm_pkg::COUNT_W;
	localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(cblm_pkg::SAMPLE_DEPTH);
	localparam logic [CW-1:0] DEPTH_CNT = CW'(cblm_pkg::SAMPLE_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(cblm_pkg::SAMPLE_DEPTH - 1);

	cblm_pkg::state_t state_q;

	logic [cblm_pkg::WIN_W-1:0]  window_q;
	logic [AW-1:0]               head_q;
	logic [CW-1:0]               count_q;
	logic [cblm_pkg::WB_W-1:0]   sum_q;
	logic [cblm_pkg::TOT_W-1:0]  frames_q;
	logic [cblm_pkg::TOT_W-1:0]  bytes_q;
	logic                        overflow_q;

	// Per-item working registers.
	logic [cblm_pkg::TS_W-1:0]   ts_q;
	logic [cblm_pkg::TS_W-1:0]   thr_q;
	logic                        none_q;
	logic [cblm_pkg::BITS_W-1:0] bits_q;
	logic                        fwd_q;

	logic                        result_valid_q;
	cblm_pkg::result_t           result_q;

	logic                          accept;
	logic                          result_free;
	logic [cblm_pkg::BITS_W-1:0]   est_bits;
	logic [AW-1:0]                 head_inc;
	logic [AW:0]                   tail_sum;
	logic [AW-1:0]                 tail;
	logic [cblm_pkg::TS_W:0]       thr_diff;
	logic [cblm_pkg::TOT_W:0]      bytes_sum;
	logic [cblm_pkg::TS_W-1:0]     head_time;
	logic [cblm_pkg::BITS_W-1:0]   head_bits;
	logic                          expire;
	logic                          ram_we;
	logic [AW-1:0]                 ram_raddr;
	logic [cblm_pkg::ENTRY_W-1:0]  ram_rdata;

	cblm_est u_est (
		.payload_length (item.payload_length),
		.extended_id    (item.extended_id),
		.frame_bits     (est_bits)
	);

	cblm_ram #(
		.WIDTH (cblm_pkg::ENTRY_W),
		.DEPTH (cblm_pkg::SAMPLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail),
		.wdata ({ts_q, bits_q}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		accept      = item_valid && (state_q == cblm_pkg::ST_IDLE);
		item_stall  = (state_q != cblm_pkg::ST_IDLE);
		result_free = !result_valid_q || !result_stall;

		head_inc = (head_q == LAST_ADDR) ? '0 : head_q + AW'(1);

		// The tail is taken only while the ring is not full.
		tail_sum = {1'b0, head_q} + {1'b0, count_q[AW-1:0]};
		if (tail_sum >= DEPTH_EXT) begin
			tail_sum = tail_sum - DEPTH_EXT;
		end
		tail = tail_sum[AW-1:0];

		// A sample expires when its time is at most now minus the window.
		// If now is below the window length nothing can expire.
		thr_diff  = {1'b0, item.item_time} - (cblm_pkg::TS_W + 1)'(window_q);
		bytes_sum = {1'b0, bytes_q} + (cblm_pkg::TOT_W + 1)'(item.payload_length);

		// Right after a push into an empty ring the head read saw stale data,
		// so the just-written sample is forwarded.
		head_time = fwd_q ? ts_q   : ram_rdata[cblm_pkg::ENTRY_W-1:cblm_pkg::BITS_W];
		head_bits = fwd_q ? bits_q : ram_rdata[cblm_pkg::BITS_W-1:0];
		expire    = (count_q != '0) && !none_q && (head_time <= thr_q);

		ram_we    = (state_q == cblm_pkg::ST_PUSH);
		ram_raddr = (state_q == cblm_pkg::ST_CHECK && expire) ? head_inc : head_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= cblm_pkg::WINDOW_RESET;
		end else if (cfg_we) begin
			window_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ts_q   <= item.item_time;
			thr_q  <= thr_diff[cblm_pkg::TS_W-1:0];
			none_q <= thr_diff[cblm_pkg::TS_W];
			bits_q <= est_bits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= cblm_pkg::ST_IDLE;
			head_q         <= '0;
			count_q        <= '0;
			sum_q          <= '0;
			frames_q       <= '0;
			bytes_q        <= '0;
			overflow_q     <= 1'b0;
			fwd_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			// A finished trim loads the result register; otherwise a taken
			// result beat empties it.
			if (state_q == cblm_pkg::ST_CHECK && !expire && result_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				cblm_pkg::ST_IDLE: begin
					if (accept) begin
						if (item.cmd == cblm_pkg::CMD_FRAME) begin
							if (frames_q != cblm_pkg::TOTAL_MAX) begin
								frames_q <= frames_q + cblm_pkg::TOT_W'(1);
							end
							bytes_q <= bytes_sum[cblm_pkg::TOT_W] ? cblm_pkg::TOTAL_MAX
							                                       : bytes_sum[cblm_pkg::TOT_W-1:0];
							state_q <= (count_q == DEPTH_CNT) ? cblm_pkg::ST_EVICT
							                                  : cblm_pkg::ST_PUSH;
						end else begin
							state_q <= cblm_pkg::ST_CHECK;
						end
					end
				end
				cblm_pkg::ST_EVICT: begin
					// The ring is full: drop the oldest sample to make room.
					sum_q      <= sum_q - cblm_pkg::WB_W'(ram_rdata[cblm_pkg::BITS_W-1:0]);
					head_q     <= head_inc;
					count_q    <= count_q - CW'(1);
					overflow_q <= 1'b1;
					state_q    <= cblm_pkg::ST_PUSH;
				end
				cblm_pkg::ST_PUSH: begin
					count_q <= count_q + CW'(1);
					sum_q   <= sum_q + cblm_pkg::WB_W'(bits_q);
					fwd_q   <= (count_q == '0);
					state_q <= cblm_pkg::ST_CHECK;
				end
				cblm_pkg::ST_CHECK: begin
					if (expire) begin
						sum_q   <= sum_q - cblm_pkg::WB_W'(head_bits);
						head_q  <= head_inc;
						count_q <= count_q - CW'(1);
						fwd_q   <= 1'b0;
					end else if (result_free) begin
						result_q.total_frames        <= frames_q;
						result_q.total_payload_bytes <= bytes_q;
						result_q.window_frames       <= cblm_pkg::WF_W'(count_q);
						result_q.window_bits         <= sum_q;
						result_q.ring_overflow       <= overflow_q;
						fwd_q                        <= 1'b0;
						state_q                      <= cblm_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= cblm_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// The ring never holds more samples than it has entries.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CNT)
		else $error("ring count exceeds depth");

	// Forwarding is only armed while the just-pushed sample is the sole one.
	a_fwd_single: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_q |-> (count_q == CW'(1)))
		else $error("forwarding armed with more than one sample");

	// A result appears only when the trim of the ring has finished.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == cblm_pkg::ST_CHECK && !expire))
		else $error("result raised outside the trim step");

	// The ring does not move while no item is being worked on.
	a_idle_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cblm_pkg::ST_IDLE && !item_valid) |=> ($stable(count_q) && $stable(head_q)))
		else $error("ring changed while idle");

endmodule

### verif/cblm_load_check_pkg.sv
`timescale 1ns / 100ps

package cblm_load_check_pkg;

	import cblm_pkg::*;

	localparam int unsigned BASE_HDR_BITS  = 47;
	localparam int unsigned EXT_HDR_BITS   = 67;
	localparam int unsigned BITS_PER_BYTE  = 8;
	localparam int unsigned MAX_DATA_BYTES = 8;
	localparam int unsigned STUFF_RUN      = 5;
	localparam int unsigned MAX_REPORTS    = 10;

	// Tracks the bus load window the way the block should, and holds the
	// figures that each accepted item beat is due to produce.
	class bus_load_tracker;
		logic [TS_W-1:0]   stamp_ring [SAMPLE_DEPTH];
		logic [BITS_W-1:0] weight_ring [SAMPLE_DEPTH];
		int unsigned       head;
		int unsigned       fill;
		int unsigned       bit_sum;
		logic [TOT_W-1:0]  frames_seen;
		logic [TOT_W-1:0]  byte_count;
		logic              overflow;
		logic [WIN_W-1:0]  window_len;
		result_t           expected_figures_q [$];
		int unsigned       failures;

		function new();
			head        = 0;
			fill        = 0;
			bit_sum     = 0;
			frames_seen = '0;
			byte_count  = '0;
			overflow    = 1'b0;
			window_len  = WINDOW_RESET;
			failures    = 0;
		endfunction

		function void set_window(logic [WIN_W-1:0] value);
			window_len = value;
		endfunction

		// Header bits, data bits with the length clamped, and one stuff bit
		// for every started group of five.
		function int unsigned estimate_bits(logic [LEN_W-1:0] len, logic ext);
			int unsigned n;
			int unsigned raw;
			n   = (len > MAX_DATA_BYTES) ? MAX_DATA_BYTES : len;
			raw = (ext ? EXT_HDR_BITS : BASE_HDR_BITS) + n * BITS_PER_BYTE;
			return raw + (raw + STUFF_RUN - 1) / STUFF_RUN;
		endfunction

		// The oldest sample goes once its age reaches the window; a sample
		// stamped later than now is never old.
		function bit aged_out(logic [TS_W-1:0] now);
			logic [TS_W-1:0] stamp;
			stamp = stamp_ring[head];
			return (now >= stamp) && ((now - stamp) >= TS_W'(window_len));
		endfunction

		function void drop_oldest();
			bit_sum -= weight_ring[head];
			head = (head + 1) % SAMPLE_DEPTH;
			fill--;
		endfunction

		function void record_item(item_t it);
			result_t     want;
			int unsigned weight;
			int unsigned tail;
			if (it.cmd == CMD_FRAME) begin
				weight = estimate_bits(it.payload_length, it.extended_id);
				if (frames_seen != TOTAL_MAX)
					frames_seen++;
				if (TOTAL_MAX - byte_count < it.payload_length)
					byte_count = TOTAL_MAX;
				else
					byte_count = byte_count + it.payload_length;
				if (fill >= SAMPLE_DEPTH) begin
					drop_oldest();
					overflow = 1'b1;
				end
				tail = (head + fill) % SAMPLE_DEPTH;
				stamp_ring[tail]  = it.item_time;
				weight_ring[tail] = BITS_W'(weight);
				fill++;
				bit_sum += weight;
			end
			while (fill > 0 && aged_out(it.item_time))
				drop_oldest();
			want.total_frames        = frames_seen;
			want.total_payload_bytes = byte_count;
			want.window_frames       = WF_W'(fill);
			want.window_bits         = WB_W'(bit_sum);
			want.ring_overflow       = overflow;
			expected_figures_q.insert(expected_figures_q.size(), want);
		endfunction

		function void check_figures(result_t got);
			result_t want;
			if (expected_figures_q.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("result beat with nothing outstanding: %s%0d %0d %0d %0d %0b",
						"frames bytes wf wb ovf = ",
						got.total_frames, got.total_payload_bytes, got.window_frames,
						got.window_bits, got.ring_overflow);
				return;
			end
			want = expected_figures_q[0];
			expected_figures_q.delete(0);
			if (got.total_frames !== want.total_frames ||
				got.total_payload_bytes !== want.total_payload_bytes ||
				got.window_frames !== want.window_frames ||
				got.window_bits !== want.window_bits ||
				got.ring_overflow !== want.ring_overflow) begin
				failures++;
				if (failures <= MAX_REPORTS) begin
					$display("%0t mismatch: expected frames=%0d bytes=%0d wf=%0d wb=%0d ovf=%0b",
						$realtime, want.total_frames, want.total_payload_bytes,
						want.window_frames, want.window_bits, want.ring_overflow);
					$display("    got frames=%0d bytes=%0d wf=%0d wb=%0d ovf=%0b",
						got.total_frames, got.total_payload_bytes, got.window_frames,
						got.window_bits, got.ring_overflow);
				end
			end
		endfunction

		function int unsigned outstanding();
			return expected_figures_q.size();
		endfunction
	endclass

endpackage

### verif/tb_can_bus_load_window_monitor_unit.sv
`timescale 1ns / 100ps

module tb_can_bus_load_window_monitor_unit;

	import cblm_pkg::*;
	import cblm_load_check_pkg::*;

	// The slowest correct run stays well inside this limit: every beat can
	// wait out a full sender gap and receiver stall, and the expiry cycles are
	// bounded by the number of frames pushed.
	localparam int unsigned CYCLE_LIMIT      = 1000000;
	localparam int unsigned LONG_HOLD_CYCLES = 400;
	localparam int unsigned HOLD_AT_BEAT     = 150;
	localparam int unsigned RANDOM_PHASES    = 8;
	localparam int unsigned PHASE_ITEMS      = 95;
	localparam int unsigned TAIL_ITEMS       = 60;
	localparam int unsigned SETTLE_CYCLES    = 8;

	localparam logic [WIN_W-1:0] WINDOW_MAX = '1;
	localparam logic [TS_W-1:0]  TS_MAX     = '1;
	localparam logic [TS_W-1:0]  TS_WIDE    = 64'h1234_5678_9ABC_DEF0;
	localparam logic [TS_W-1:0]  TS_MSB     = 64'h8000_0000_0000_0000;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_stall;
	item_t             item;
	logic              result_valid;
	logic              result_stall;
	result_t           result;
	logic              cfg_we;
	logic [WIN_W-1:0]  cfg_wdata;

	bus_load_tracker   load_tracker;
	int unsigned       cycle_count;
	bit                sender_burst;
	logic [TS_W-1:0]   stim_time;
	logic [WIN_W-1:0]  window_now;

	can_bus_load_window_monitor_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic item_t make_item(logic cmd, logic [TS_W-1:0] ts,
		logic [LEN_W-1:0] len, logic ext);
		item_t it;
		it.cmd            = cmd;
		it.item_time      = ts;
		it.payload_length = len;
		it.extended_id    = ext;
		return it;
	endfunction

	function automatic logic [TS_W-1:0] random_stamp();
		return {$urandom, $urandom};
	endfunction

	// Offers one item beat after a random gap, then holds it steady until the
	// block takes it. Inputs change on the falling edge; the handshake is read
	// on the rising edge, before the block's own updates for that edge land.
	// A zero gap keeps valid high straight into the next beat.
	task automatic send_item(input item_t it);
		int unsigned gap;
		gap = sender_burst ? 0 : $urandom_range(0, 19);
		repeat (gap) @(negedge clk) item_valid <= 1'b0;
		@(negedge clk);
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (item_stall);
		load_tracker.record_item(it);
		// Flip between gappy and back-to-back stretches now and then.
		if ($urandom_range(0, 15) == 0)
			sender_burst = !sender_burst;
	endtask

	// Drops valid and waits until every outstanding result beat has arrived,
	// then lets the block settle so that it is truly idle.
	task automatic settle();
		@(negedge clk) item_valid <= 1'b0;
		while (load_tracker.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Only called while the block is idle.
	task automatic write_window(input logic [WIN_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		load_tracker.set_window(value);
		window_now = value;
	endtask

	// Mostly a clock that moves forward in steps small against the window,
	// so that samples build up and age out a few at a time. The rest is a
	// jump past the whole window, a step backward that leaves the ring with
	// samples stamped after now, or a stamp anywhere in the 64-bit range.
	task automatic run_random_phase(input int unsigned count);
		logic [TS_W-1:0] step_cap;
		int unsigned     step_max;
		int unsigned     roll;
		logic            cmd;
		step_cap = (TS_W'(window_now) >> 3) + 1;
		step_max = (step_cap > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : step_cap[31:0];
		for (int unsigned i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 85)
				stim_time = stim_time + TS_W'($urandom_range(0, step_max));
			else if (roll < 90)
				stim_time = stim_time + TS_W'(window_now) + TS_W'($urandom_range(0, 1000));
			else if (roll < 95)
				stim_time = stim_time - TS_W'($urandom_range(0, step_max));
			else
				stim_time = random_stamp();
			cmd = ($urandom_range(0, 3) == 0) ? CMD_QUERY : CMD_FRAME;
			send_item(make_item(cmd, stim_time, LEN_W'($urandom_range(0, 15)),
				1'($urandom_range(0, 1))));
		end
	endtask

	// Result side: before each beat it draws a random stall, with stretches of
	// no stall at all. Once, early in the run, it holds off for a long stretch
	// while the sender keeps offering, so that the result register and the item
	// stage both back up and the block stalls its input.
	initial begin : result_sink
		int unsigned hold;
		int unsigned beats;
		bit          steady;
		result_stall = 1'b0;
		beats        = 0;
		steady       = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (beats == HOLD_AT_BEAT)
				hold = LONG_HOLD_CYCLES;
			else
				hold = steady ? 0 : $urandom_range(0, 19);
			repeat (hold) @(negedge clk) result_stall <= 1'b1;
			@(negedge clk) result_stall <= 1'b0;
			do @(posedge clk); while (!(result_valid && !result_stall));
			load_tracker.check_figures(result);
			beats++;
			if ($urandom_range(0, 15) == 0)
				steady = !steady;
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("can_bus_load_window_monitor_unit verification failed");
		$finish;
	end

	initial begin : stimulus
		load_tracker = new();
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		sender_burst = 1'b0;
		stim_time    = '0;
		window_now   = WINDOW_RESET;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed part, first at the window length left by reset. A query on
		// an empty ring, frames of both header kinds at the length extremes,
		// lengths above eight that count raw in the byte total but clamped in
		// the bit estimate, and a query whose length and header fields must be
		// ignored.
		send_item(make_item(CMD_QUERY, '0, '0, 1'b0));
		send_item(make_item(CMD_FRAME, 64'd100, 4'd0, 1'b0));
		send_item(make_item(CMD_FRAME, 64'd200, 4'd8, 1'b1));
		send_item(make_item(CMD_FRAME, 64'd300, 4'd15, 1'b1));
		send_item(make_item(CMD_FRAME, 64'd400, 4'd9, 1'b0));
		send_item(make_item(CMD_QUERY, 64'd500, 4'd15, 1'b1));
		// A frame stamped at the end of time sits in the ring as a sample
		// newer than every later query, so expiry has to stop in front of it.
		send_item(make_item(CMD_FRAME, TS_MAX, 4'd5, 1'b0));
		send_item(make_item(CMD_QUERY, 64'd1000000150, '0, 1'b0));
		send_item(make_item(CMD_QUERY, 64'd2000000000, '0, 1'b0));
		send_item(make_item(CMD_FRAME, '0, 4'd1, 1'b1));
		settle();

		// A zero window expires everything not newer than now, including a
		// frame on its own beat right after it is pushed.
		write_window('0);
		send_item(make_item(CMD_QUERY, TS_MAX, '0, 1'b0));
		send_item(make_item(CMD_FRAME, 64'd1000, 4'd3, 1'b0));
		send_item(make_item(CMD_FRAME, 64'd5, 4'd7, 1'b1));
		settle();

		// Widest window: the age test must hold one short of the full length
		// and trip exactly at it.
		write_window(WINDOW_MAX);
		send_item(make_item(CMD_FRAME, TS_WIDE, 4'd2, 1'b1));
		send_item(make_item(CMD_FRAME, TS_WIDE + 1, 4'd15, 1'b0));
		send_item(make_item(CMD_QUERY, TS_WIDE + TS_W'(WINDOW_MAX) - 1, '0, 1'b0));
		send_item(make_item(CMD_QUERY, TS_WIDE + TS_W'(WINDOW_MAX), '0, 1'b0));
		send_item(make_item(CMD_QUERY, TS_WIDE + TS_W'(WINDOW_MAX) + 1, '0, 1'b0));
		settle();

		// One-nanosecond window with frames sharing a time stamp.
		write_window(40'd1);
		send_item(make_item(CMD_FRAME, TS_MSB, 4'd4, 1'b0));
		send_item(make_item(CMD_FRAME, TS_MSB, 4'd6, 1'b1));
		send_item(make_item(CMD_QUERY, TS_MSB + 1, '0, 1'b0));
		send_item(make_item(CMD_FRAME, TS_MSB + 1, 4'd8, 1'b0));
		settle();

		// Random phases, each under its own window length. The sender waits
		// for every result beat at the end of each phase.
		for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: write_window(40'd1);
				1: write_window(WIN_W'($urandom_range(2, 2000)));
				2: write_window(WIN_W'($urandom_range(10000, 1000000)));
				3: write_window(WINDOW_RESET);
				4: write_window({8'($urandom_range(0, 255)), $urandom});
				5: write_window(WIN_W'($urandom_range(100, 5000)));
				6: write_window(WINDOW_MAX);
				default: write_window(WIN_W'($urandom_range(1, 64)));
			endcase
			if ($urandom_range(0, 1) == 1)
				stim_time = random_stamp();
			run_random_phase(PHASE_ITEMS);
			settle();
		end

		// A last random run back at the window length left by reset.
		write_window(WINDOW_RESET);
		run_random_phase(TAIL_ITEMS);
		settle();

		if (load_tracker.failures == 0 && load_tracker.outstanding() == 0)
			$display("can_bus_load_window_monitor_unit verification clean");
		else
			$display("can_bus_load_window_monitor_unit verification failed");
		$finish;
	end

endmodule
